@@ src/pwrtm_pkg.sv @@
// Shared types, constants and command codes for the pulse-width range trimmed-mean block.
`default_nettype none
package pwrtm_pkg;

  localparam int WINDOW_LEN_DEF = 12;
  localparam int US_PER_CM_DEF  = 10;

  localparam int EC_W      = 16;
  localparam int CFG_W     = 16;
  localparam int CFG_IDX_W = 1;
  localparam int DIST_W    = 13;
  localparam int KIND_W    = 2;

  localparam logic [DIST_W-1:0] DIST_MAX = 13'h1FFF;

  localparam logic [CFG_W-1:0] TIMEOUT_RST = 16'd10000;
  localparam logic [CFG_W-1:0] RESTART_RST = 16'd4000;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RESTART = 1'd1;

  // Result kinds.
  localparam logic [KIND_W-1:0] KIND_RAW     = 2'd0;
  localparam logic [KIND_W-1:0] KIND_AVG     = 2'd1;
  localparam logic [KIND_W-1:0] KIND_TIMEOUT = 2'd2;
  localparam logic [KIND_W-1:0] KIND_ZERO    = 2'd3;

  typedef logic [3:0] op_t;

  // Datapath operations issued by the controller.
  localparam op_t OP_NONE        = 4'd0;
  localparam op_t OP_RESTART     = 4'd1;
  localparam op_t OP_RISE        = 4'd2;
  localparam op_t OP_COUNT       = 4'd3;
  localparam op_t OP_TIMEOUT     = 4'd4;
  localparam op_t OP_FALL        = 4'd5;
  localparam op_t OP_ZERO        = 4'd6;
  localparam op_t OP_RAW         = 4'd7;
  localparam op_t OP_INSERT_SCAN = 4'd8;
  localparam op_t OP_SCAN_MM     = 4'd9;
  localparam op_t OP_SCAN_SUM    = 4'd10;
  localparam op_t OP_HELD        = 4'd11;
  localparam op_t OP_START_AVG   = 4'd12;
  localparam op_t OP_AVG_DONE    = 4'd13;

  typedef struct packed {
    op_t  op;
    logic capture;
    logic emit;
  } ctrl_cmd_t;

  typedef struct packed {
    logic restart_active;
    logic in_pulse;
    logic pin;
    logic timeout_hit;
    logic div_done;
    logic dist_zero;
    logic fill_next_full;
    logic scan_last;
    logic cnt_zero;
    logic out_free;
  } dp_stat_t;

endpackage
`default_nettype wire

@@ src/pwrtm_div.sv @@
// Restoring serial divider, one quotient bit per cycle.
`default_nettype none
module pwrtm_div
  import pwrtm_pkg::*;
#(
  parameter int DVD_W = 17,
  parameter int DVS_W = 7
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  input  wire logic [DVD_W-1:0] dividend,
  input  wire logic [DVS_W-1:0] divisor,
  output logic                  done,
  output logic      [DVD_W-1:0] quotient
);

  localparam int CNT_W = $clog2(DVD_W);

  logic             busy_r;
  logic             done_r;
  logic [DVD_W-1:0] quo_r;
  logic [DVS_W-1:0] rem_r;
  logic [DVS_W-1:0] den_r;
  logic [CNT_W-1:0] cnt_r;

  logic [DVS_W:0]   shifted;
  logic             step_bit;
  logic [DVS_W:0]   step_rem;

  always_comb begin
    shifted  = {rem_r, quo_r[DVD_W-1]};
    step_bit = (shifted >= {1'b0, den_r});
    step_rem = step_bit ? (shifted - {1'b0, den_r}) : shifted;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
      end else if (busy_r && (cnt_r == '0)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      rem_r <= '0;
      den_r <= divisor;
      cnt_r <= CNT_W'(DVD_W - 1);
    end else if (busy_r) begin
      rem_r <= step_rem[DVS_W-1:0];
      quo_r <= {quo_r[DVD_W-2:0], step_bit};
      cnt_r <= cnt_r - CNT_W'(1);
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule
`default_nettype wire

@@ src/pwrtm_dp.sv @@
// Datapath: pulse timing, window, min/max and sum scan, divider and result registers.
`default_nettype none
module pwrtm_dp
  import pwrtm_pkg::*;
#(
  parameter int WINDOW_LEN = WINDOW_LEN_DEF,
  parameter int US_PER_CM  = US_PER_CM_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire ctrl_cmd_t            cmd,
  output dp_stat_t                  stat,
  input  wire logic                 in_pin_level,
  input  wire logic                 cfg_wr_en,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]     cfg_data,
  input  wire logic                 out_ready,
  output logic                      out_valid,
  output logic                      out_sensor_enable,
  output logic                      out_result_valid,
  output logic      [DIST_W-1:0]    out_distance_cm,
  output logic      [KIND_W-1:0]    out_result_kind
);

  localparam int IDX_W   = $clog2(WINDOW_LEN);
  localparam int FILL_W  = $clog2(WINDOW_LEN + 1);
  localparam int SUM_W   = DIST_W + $clog2(WINDOW_LEN);
  localparam int DVD_W   = SUM_W;
  localparam int DVS_W   = FILL_W;
  // Scaled reciprocal of US_PER_CM; the product gives the exact floor for any 16-bit
  // pulse length.
  localparam int CONV_SH = EC_W + $clog2(US_PER_CM);
  localparam int CONV_W  = EC_W + 1;
  localparam int PROD_W  = EC_W + CONV_W;
  localparam logic [CONV_W-1:0] CONV_MUL =
    CONV_W'(((1 << CONV_SH) + US_PER_CM - 1) / US_PER_CM);

  logic              pin_r;
  logic [EC_W-1:0]   ec_r;
  logic              in_pulse_r;
  logic [DIST_W-1:0] win_r [WINDOW_LEN];
  logic [FILL_W-1:0] fill_r;
  logic [DIST_W-1:0] held_r;
  logic [CFG_W-1:0]  rc_r;
  logic [CFG_W-1:0]  timeout_r;
  logic [CFG_W-1:0]  restart_r;
  logic [IDX_W-1:0]  idx_r;
  logic [DIST_W-1:0] lo_r;
  logic [DIST_W-1:0] hi_r;
  logic [SUM_W-1:0]  sum_r;
  logic [FILL_W-1:0] cnt_r;
  logic [DIST_W-1:0] fall_dist_r;

  logic              res_en_r;
  logic              res_vld_r;
  logic [DIST_W-1:0] res_dist_r;
  logic [KIND_W-1:0] res_kind_r;

  logic              out_valid_r;
  logic              out_en_r;
  logic              out_vld_r;
  logic [DIST_W-1:0] out_dist_r;
  logic [KIND_W-1:0] out_kind_r;

  logic              div_start;
  logic [DVD_W-1:0]  div_dvd;
  logic [DVS_W-1:0]  div_dvs;
  logic              div_done;
  logic [DVD_W-1:0]  div_quo;
  logic [DIST_W-1:0] dist_c;
  logic [PROD_W-1:0] conv_prod;
  logic [EC_W-1:0]   conv_quo;
  logic [DIST_W-1:0] conv_dist;
  logic [DIST_W-1:0] win_rd;
  logic              scan_last;

  // The pulse length is converted by reciprocal multiplication; the divider only
  // serves the trimmed average.
  always_comb begin
    div_start = (cmd.op == OP_START_AVG);
    div_dvd   = DVD_W'(sum_r);
    div_dvs   = DVS_W'(cnt_r);
    dist_c    = (div_quo > DVD_W'(DIST_MAX)) ? DIST_MAX : div_quo[DIST_W-1:0];
    conv_prod = PROD_W'(ec_r) * PROD_W'(CONV_MUL);
    conv_quo  = EC_W'(conv_prod >> CONV_SH);
    conv_dist = (conv_quo > EC_W'(DIST_MAX)) ? DIST_MAX : conv_quo[DIST_W-1:0];
    win_rd    = win_r[idx_r];
    scan_last = (idx_r == IDX_W'(WINDOW_LEN - 1));
  end

  pwrtm_div #(
    .DVD_W(DVD_W),
    .DVS_W(DVS_W)
  ) u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (div_start),
    .dividend(div_dvd),
    .divisor (div_dvs),
    .done    (div_done),
    .quotient(div_quo)
  );

  always_comb begin
    stat.restart_active = (rc_r != '0);
    stat.in_pulse       = in_pulse_r;
    stat.pin            = pin_r;
    stat.timeout_hit    = (ec_r >= timeout_r);
    stat.div_done       = div_done;
    stat.dist_zero      = (fall_dist_r == '0);
    stat.fill_next_full = (fill_r >= FILL_W'(WINDOW_LEN - 1));
    stat.scan_last      = scan_last;
    stat.cnt_zero       = (cnt_r == '0);
    stat.out_free       = !out_valid_r || out_ready;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ec_r        <= '0;
      in_pulse_r  <= 1'b0;
      fill_r      <= '0;
      held_r      <= '0;
      rc_r        <= '0;
      timeout_r   <= TIMEOUT_RST;
      restart_r   <= RESTART_RST;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        unique case (cfg_index)
          CFG_TIMEOUT: timeout_r <= cfg_data;
          CFG_RESTART: restart_r <= cfg_data;
          default: ;
        endcase
      end
      unique case (cmd.op)
        OP_RESTART: rc_r <= rc_r - CFG_W'(1);
        OP_RISE: begin
          in_pulse_r <= 1'b1;
          ec_r       <= EC_W'(1);
        end
        OP_COUNT: ec_r <= ec_r + EC_W'(1);
        OP_TIMEOUT, OP_FALL: begin
          in_pulse_r <= 1'b0;
          ec_r       <= '0;
        end
        // A zero restart time still holds the enable low for the current tick.
        OP_ZERO: rc_r <= (restart_r != '0) ? (restart_r - CFG_W'(1)) : '0;
        OP_RAW, OP_INSERT_SCAN: begin
          if (fill_r < FILL_W'(WINDOW_LEN)) begin
            fill_r <= fill_r + FILL_W'(1);
          end
        end
        OP_AVG_DONE: held_r <= dist_c;
        default: ;
      endcase
      if (cmd.emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      pin_r <= in_pin_level;
    end
    unique case (cmd.op)
      OP_RESTART: begin
        res_en_r   <= 1'b0;
        res_vld_r  <= 1'b0;
        res_dist_r <= '0;
        res_kind_r <= KIND_RAW;
      end
      OP_RISE, OP_COUNT: begin
        res_en_r   <= 1'b1;
        res_vld_r  <= 1'b0;
        res_dist_r <= '0;
        res_kind_r <= KIND_RAW;
      end
      OP_TIMEOUT: begin
        res_en_r   <= 1'b1;
        res_vld_r  <= 1'b1;
        res_dist_r <= held_r;
        res_kind_r <= KIND_TIMEOUT;
      end
      OP_FALL: fall_dist_r <= conv_dist;
      OP_ZERO: begin
        res_en_r   <= 1'b0;
        res_vld_r  <= 1'b1;
        res_dist_r <= held_r;
        res_kind_r <= KIND_ZERO;
      end
      OP_RAW: begin
        for (int i = WINDOW_LEN - 1; i > 0; i--) begin
          win_r[i] <= win_r[i-1];
        end
        win_r[0]   <= fall_dist_r;
        res_en_r   <= 1'b1;
        res_vld_r  <= 1'b1;
        res_dist_r <= fall_dist_r;
        res_kind_r <= KIND_RAW;
      end
      OP_INSERT_SCAN: begin
        for (int i = WINDOW_LEN - 1; i > 0; i--) begin
          win_r[i] <= win_r[i-1];
        end
        win_r[0] <= fall_dist_r;
        lo_r     <= fall_dist_r;
        hi_r     <= fall_dist_r;
        idx_r    <= IDX_W'(1);
      end
      OP_SCAN_MM: begin
        if (win_rd < lo_r) begin
          lo_r <= win_rd;
        end
        if (win_rd > hi_r) begin
          hi_r <= win_rd;
        end
        if (scan_last) begin
          idx_r <= '0;
          sum_r <= '0;
          cnt_r <= '0;
        end else begin
          idx_r <= idx_r + IDX_W'(1);
        end
      end
      OP_SCAN_SUM: begin
        if ((win_rd > lo_r) && (win_rd < hi_r)) begin
          sum_r <= sum_r + SUM_W'(win_rd);
          cnt_r <= cnt_r + FILL_W'(1);
        end
        idx_r <= scan_last ? '0 : (idx_r + IDX_W'(1));
      end
      OP_HELD: begin
        res_en_r   <= 1'b1;
        res_vld_r  <= 1'b1;
        res_dist_r <= held_r;
        res_kind_r <= KIND_AVG;
      end
      OP_AVG_DONE: begin
        res_en_r   <= 1'b1;
        res_vld_r  <= 1'b1;
        res_dist_r <= dist_c;
        res_kind_r <= KIND_AVG;
      end
      default: ;
    endcase
    if (cmd.emit) begin
      out_en_r   <= res_en_r;
      out_vld_r  <= res_vld_r;
      out_dist_r <= res_dist_r;
      out_kind_r <= res_kind_r;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_sensor_enable = out_en_r;
  assign out_result_valid  = out_vld_r;
  assign out_distance_cm   = out_dist_r;
  assign out_result_kind   = out_kind_r;

endmodule
`default_nettype wire

@@ src/pwrtm_ctrl.sv @@
// Controller state machine sequencing one tick through the datapath.
`default_nettype none
module pwrtm_ctrl
  import pwrtm_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_ready,
  input  wire dp_stat_t stat,
  output ctrl_cmd_t     cmd
);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_EVAL = 4'd1;
  localparam logic [3:0] S_DIST = 4'd2;
  localparam logic [3:0] S_MM   = 4'd3;
  localparam logic [3:0] S_SUM  = 4'd4;
  localparam logic [3:0] S_SUMD = 4'd5;
  localparam logic [3:0] S_DIVA = 4'd6;
  localparam logic [3:0] S_EMIT = 4'd7;

  logic [3:0] state_r;
  logic [3:0] state_nxt;

  always_comb begin
    state_nxt   = state_r;
    in_ready    = 1'b0;
    cmd.op      = OP_NONE;
    cmd.capture = 1'b0;
    cmd.emit    = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready    = 1'b1;
        cmd.capture = in_valid;
        if (in_valid) begin
          state_nxt = S_EVAL;
        end
      end
      S_EVAL: begin
        state_nxt = S_EMIT;
        priority if (stat.restart_active) begin
          cmd.op = OP_RESTART;
        end else if (!stat.in_pulse) begin
          priority if (stat.pin) begin
            cmd.op = OP_RISE;
          end else if (stat.timeout_hit) begin
            cmd.op = OP_TIMEOUT;
          end else begin
            cmd.op = OP_COUNT;
          end
        end else if (stat.pin) begin
          cmd.op = stat.timeout_hit ? OP_TIMEOUT : OP_COUNT;
        end else begin
          // Falling edge: the pulse length is converted to centimeters.
          cmd.op    = OP_FALL;
          state_nxt = S_DIST;
        end
      end
      S_DIST: begin
        priority if (stat.dist_zero) begin
          cmd.op    = OP_ZERO;
          state_nxt = S_EMIT;
        end else if (stat.fill_next_full) begin
          cmd.op    = OP_INSERT_SCAN;
          state_nxt = S_MM;
        end else begin
          cmd.op    = OP_RAW;
          state_nxt = S_EMIT;
        end
      end
      S_MM: begin
        cmd.op = OP_SCAN_MM;
        if (stat.scan_last) begin
          state_nxt = S_SUM;
        end
      end
      S_SUM: begin
        cmd.op = OP_SCAN_SUM;
        if (stat.scan_last) begin
          state_nxt = S_SUMD;
        end
      end
      S_SUMD: begin
        if (stat.cnt_zero) begin
          cmd.op    = OP_HELD;
          state_nxt = S_EMIT;
        end else begin
          cmd.op    = OP_START_AVG;
          state_nxt = S_DIVA;
        end
      end
      S_DIVA: begin
        if (stat.div_done) begin
          cmd.op    = OP_AVG_DONE;
          state_nxt = S_EMIT;
        end
      end
      S_EMIT: begin
        if (stat.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule
`default_nettype wire

@@ src/pulse_width_range_trimmed_mean_top.sv @@
// Top level of the pulse-width range sensor with trimmed moving average.
`default_nettype none
// Each input transfer is one microsecond tick of the sensor's PWM pin and yields exactly
// one output transfer. An ordinary tick is accepted, evaluated and loaded into the output
// register. A falling-edge tick converts the pulse length to centimeters with a
// reciprocal multiplication and then passes the S_DIST step, which leads straight to the
// output on a zero reading or while the window fills. Once the window is full it also
// scans the window twice, one entry per cycle, and divides the trimmed sum by its count
// in a serial divider that produces one quotient bit per cycle over DVD_W =
// 13 + clog2(WINDOW_LEN) bits; when the trimmed set is empty the division is skipped.
// A stall on the output holds the tick until the previous result is taken. A new tick is
// accepted while the previous result still waits in the output register.
module pulse_width_range_trimmed_mean_top
  import pwrtm_pkg::*;
#(
  parameter int WINDOW_LEN = WINDOW_LEN_DEF,
  parameter int US_PER_CM  = US_PER_CM_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire logic                 in_pin_level,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output logic                      out_sensor_enable,
  output logic                      out_result_valid,
  output logic      [DIST_W-1:0]    out_distance_cm,
  output logic      [KIND_W-1:0]    out_result_kind,
  input  wire logic                 cfg_wr_en,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]     cfg_data
);

  ctrl_cmd_t cmd;
  dp_stat_t  stat;

  pwrtm_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .stat    (stat),
    .cmd     (cmd)
  );

  pwrtm_dp #(
    .WINDOW_LEN(WINDOW_LEN),
    .US_PER_CM (US_PER_CM)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .stat             (stat),
    .in_pin_level     (in_pin_level),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .out_ready        (out_ready),
    .out_valid        (out_valid),
    .out_sensor_enable(out_sensor_enable),
    .out_result_valid (out_result_valid),
    .out_distance_cm  (out_distance_cm),
    .out_result_kind  (out_result_kind)
  );

  // A result must never overwrite one that has not been transferred.
  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> (!out_valid || out_ready))
    else $error("result loaded over a pending output");

  // The divider only finishes while the controller is busy with a tick.
  a_div_busy: assert property (@(posedge clk) disable iff (!rst_n)
    stat.div_done |-> !in_ready)
    else $error("divider finished while controller idle");

  // Ticks without a reading carry zero distance and kind.
  a_no_reading: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_result_valid) |-> (out_distance_cm == '0 && out_result_kind == KIND_RAW))
    else $error("non-reading result carries data");

  // A reading with the sensor disabled is always the zero-reading restart.
  a_zero_restart: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_result_valid && !out_sensor_enable) |-> (out_result_kind == KIND_ZERO))
    else $error("sensor disabled on a reading that is not a zero reading");

endmodule
`default_nettype wire
